// ----- rtl/core/fpa_pkg.sv -----
// Package: opcodes and cell control types for the Q24.8 fixed-point ALU.
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_ITOF = 4'd8,
        OP_FTOI = 4'd9
    } op_t;

    // control carried alongside each word through the cell row
    typedef struct packed {
        logic        valid;
        logic        is_div;
        logic        is_mul;
        logic        neg;
        logic        dz;
        logic        equal;
        logic        less;
        logic        greater;
        logic [31:0] fast_val;
    } ctl_t;

endpackage

// ----- rtl/core/fpa_cell.sv -----
// One divide cell: a restoring step of the quotient magnitude per stage.
module fpa_cell
    import fpa_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 33
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ctl_t          ctl_in,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] den_in,
    input  logic [NW-1:0] quo_in,
    input  logic [63:0]   prod_in,
    output ctl_t          ctl_out,
    output logic [NW-1:0] num_out,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] den_out,
    output logic [NW-1:0] quo_out,
    output logic [63:0]   prod_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    ctl_t          ctl_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] quo_reg;
    logic [63:0]   prod_reg;

    always_comb
    begin
        trial = {rem_in, num_in[NW-1]};
        diff  = trial - {1'b0, den_in};
        take  = !diff[DW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= {num_in[NW-2:0], 1'b0};
            rem_reg  <= take ? diff[DW-1:0] : trial[DW-1:0];
            den_reg  <= den_in;
            quo_reg  <= {quo_in[NW-2:0], take};
            prod_reg <= prod_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign prod_out = prod_reg;

endmodule

// ----- rtl/core/fixed_point_alu_q24_8.sv -----
// Top level: Q24.8 fixed-point ALU, a row of divide cells with a pipelined multiply.
//
//  channel | signals                                       | role
//  in      | in_valid, in_ready, kind, operand_a, operand_b | one word per op
//  out     | out_valid, out_ready, value, flags             | one result word
//
// The divide cell row gives one quotient bit per cell; one word enters
// every cycle while the output register is free or taken.
// The whole row advances only when the output register is free or taken,
// so a stall on out freezes every cell. Reset clears all valid bits.
module fixed_point_alu_q24_8
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic               equal,
    output logic               less,
    output logic               greater,
    output logic               overflow,
    output logic               div_by_zero
);

    localparam int NW    = 32 + FRACTION_BITS;
    localparam int DW    = 33;
    localparam int CELLS = NW;

    logic        en;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] fast;
    ctl_t        ctl0;

    ctl_t          ctl_c  [CELLS+1];
    logic [NW-1:0] num_c  [CELLS+1];
    logic [DW-1:0] rem_c  [CELLS+1];
    logic [DW-1:0] den_c  [CELLS+1];
    logic [NW-1:0] quo_c  [CELLS+1];
    logic [63:0]   prod_c [CELLS+1];

    ctl_t          ctl_reg;
    logic [63:0]   prod_reg;
    logic          ov_reg;

    ctl_t        ctl_out_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic        ovf_reg;
    logic [64:0] mag_next;
    logic        ovf_next;
    logic [31:0] val_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign mag_a    = operand_a[31] ? 32'(-operand_a) : operand_a;
    assign mag_b    = operand_b[31] ? 32'(-operand_b) : operand_b;

    always_comb
    begin
        fast = '0;
        case (kind)
            OP_ADD:  fast = operand_a + operand_b;
            OP_SUB:  fast = operand_a - operand_b;
            OP_MIN:  fast = (operand_a < operand_b) ? operand_a : operand_b;
            OP_MAX:  fast = (operand_a > operand_b) ? operand_a : operand_b;
            OP_INC:  fast = operand_a + 32'd1;
            OP_DEC:  fast = operand_a - 32'd1;
            OP_ITOF: fast = operand_a << FRACTION_BITS;
            OP_FTOI: fast = operand_a >>> FRACTION_BITS;
            OP_DIV:  fast = operand_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: fast = '0;
        endcase
        ctl0          = '0;
        ctl0.valid    = in_valid;
        ctl0.is_div   = (kind == OP_DIV) && (operand_b != 0);
        ctl0.is_mul   = (kind == OP_MUL);
        ctl0.neg      = operand_a[31] ^ operand_b[31];
        ctl0.dz       = (kind == OP_DIV) && (operand_b == 0);
        ctl0.equal    = operand_a == operand_b;
        ctl0.less     = operand_a < operand_b;
        ctl0.greater  = operand_a > operand_b;
        ctl0.fast_val = fast;
    end

    // Entry register; product of magnitudes, numerator is |a| << F
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_c[0] <= '0;
        end
        else if (en)
        begin
            ctl_c[0] <= ctl0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_c[0]  <= NW'({mag_a, {FRACTION_BITS{1'b0}}});
            rem_c[0]  <= '0;
            den_c[0]  <= {1'b0, mag_b};
            quo_c[0]  <= '0;
            prod_c[0] <= 64'(mag_a) * 64'(mag_b);
        end
    end

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        fpa_cell #(.NW(NW), .DW(DW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (ctl_c[i]),
            .num_in   (num_c[i]),
            .rem_in   (rem_c[i]),
            .den_in   (den_c[i]),
            .quo_in   (quo_c[i]),
            .prod_in  (prod_c[i]),
            .ctl_out  (ctl_c[i+1]),
            .num_out  (num_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .den_out  (den_c[i+1]),
            .quo_out  (quo_c[i+1]),
            .prod_out (prod_c[i+1])
        );
    end

    // Rounding stage: div rounds up when 2*rem >= den; mul adds half an lsb
    always_comb
    begin
        if (ctl_c[CELLS].is_div)
        begin
            mag_next = 65'(quo_c[CELLS]) +
                65'(({1'b0, rem_c[CELLS]} << 1) >= {1'b0, den_c[CELLS]});
        end
        else
        begin
            mag_next = (65'(prod_c[CELLS]) + (65'(1) << FRACTION_BITS >> 1))
                >> FRACTION_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_c[CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mag_next[63:0];
            ov_reg   <= mag_next[64];
        end
    end

    // Sign and saturate
    always_comb
    begin
        ovf_next = 1'b0;
        val_next = ctl_reg.fast_val;
        if (ctl_reg.is_mul || ctl_reg.is_div)
        begin
            if (ctl_reg.neg && prod_reg != 0)
            begin
                if (ov_reg || prod_reg > 64'h8000_0000)
                begin
                    ovf_next = 1'b1;
                    val_next = 32'h8000_0000;
                end
                else
                begin
                    val_next = 32'(-prod_reg[31:0]);
                end
            end
            else if (ov_reg || prod_reg > 64'h7FFF_FFFF)
            begin
                ovf_next = 1'b1;
                val_next = 32'h7FFF_FFFF;
            end
            else
            begin
                val_next = prod_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg   <= val_next;
            ovf_reg     <= ovf_next;
            ctl_out_reg <= ctl_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign equal       = ctl_out_reg.equal;
    assign less        = ctl_out_reg.less;
    assign greater     = ctl_out_reg.greater;
    assign overflow    = ovf_reg;
    assign div_by_zero = ctl_out_reg.dz;

`ifndef SYNTH
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({equal, less, greater}) == 1)
        else $error("compare flags not exclusive");
    a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> !overflow)
        else $error("divide by zero with overflow");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value) && out_valid)
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready mismatch");
`endif

endmodule
